/* rtl/bhwc_pkg.sv */
package bhwc_pkg;

  localparam int DEF_COORD_BITS  = 18;
  localparam int DEF_ENERGY_BITS = 16;

  localparam int BAR_W     = 32;
  localparam int ESUM_W    = 32;
  localparam int ACC_W     = 48;
  localparam int ACC_EXT_W = 58;
  localparam int DIV_W     = 64;
  localparam int CMP_W     = 34;

  localparam int XLIM_W   = 17;
  localparam int BOUND_W  = 18;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [XLIM_W-1:0]         X_LIMIT_RST = 17'd16000;
  localparam logic signed [BOUND_W-1:0] Y_LOW_RST   = -18'sd15695;
  localparam logic signed [BOUND_W-1:0] Y_HIGH_RST  = 18'sd16305;
  localparam logic signed [BOUND_W-1:0] Z_LOW_RST   = 18'sd13440;
  localparam logic signed [BOUND_W-1:0] Z_HIGH_RST  = 18'sd88704;

  typedef enum logic [2:0] {
    REG_X_LIMIT,
    REG_Y_LOW,
    REG_Y_HIGH,
    REG_Z_LOW,
    REG_Z_HIGH
  } reg_idx_t;

  typedef enum logic [1:0] {
    SEL_X,
    SEL_Y,
    SEL_Z
  } coord_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROD,
    S_DECIDE,
    S_EMIT,
    S_DIV,
    S_OUT,
    S_ACCUM,
    S_EOE
  } state_t;

  typedef struct packed {
    logic [XLIM_W-1:0]  x_limit;
    logic [BOUND_W-1:0] y_low;
    logic [BOUND_W-1:0] y_high;
    logic [BOUND_W-1:0] z_low;
    logic [BOUND_W-1:0] z_high;
  } cfg_t;

  typedef struct packed {
    logic       take_in;
    logic       calc;
    logic       accum;
    logic       div_start;
    coord_sel_t num_sel;
    logic       store;
    coord_sel_t store_sel;
    logic       out_load;
    logic       out_last;
    logic       clear;
  } cmd_t;

  typedef struct packed {
    logic in_box;
    logic have_bar;
    logic bar_ne;
    logic eoe;
    logic e_zero;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

/* rtl/bhwc_div.sv */
module bhwc_div #(
  parameter int QW = bhwc_pkg::DEF_COORD_BITS + 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bhwc_pkg::DIV_W-1:0] num,
  input  logic [bhwc_pkg::ESUM_W-1:0] den,
  output logic                       busy,
  output logic                       done,
  output logic [QW-1:0]              quo
);
  import bhwc_pkg::*;

  localparam int CNT_W = $clog2(QW + 1);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsh;
  logic [CNT_W-1:0] cnt;
  logic             ge;

  assign ge = (rem >= dsh);

  // restoring division, one quotient bit per cycle, msb first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= DIV_W'(den) << (QW - 1);
      quo <= '0;
      cnt <= CNT_W'(QW);
    end else if (busy) begin
      rem <= ge ? rem - dsh : rem;
      quo <= {quo[QW-2:0], ge};
      dsh <= dsh >> 1;
      cnt <= cnt - CNT_W'(1);
    end
  end

endmodule

/* rtl/bhwc_dp.sv */
module bhwc_dp #(
  parameter int COORD_BITS  = bhwc_pkg::DEF_COORD_BITS,
  parameter int ENERGY_BITS = bhwc_pkg::DEF_ENERGY_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bhwc_pkg::cfg_t                 cfg,
  input  bhwc_pkg::cmd_t                 cmd,
  output bhwc_pkg::status_t              status,
  input  logic signed [COORD_BITS-1:0]   x_pos,
  input  logic signed [COORD_BITS-1:0]   y_pos,
  input  logic signed [COORD_BITS-1:0]   z_pos,
  input  logic [ENERGY_BITS-1:0]         energy,
  input  logic [bhwc_pkg::BAR_W-1:0]     bar_id,
  input  logic                           end_of_event,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [COORD_BITS-1:0]   cent_x,
  output logic signed [COORD_BITS-1:0]   cent_y,
  output logic signed [COORD_BITS-1:0]   cent_z,
  output logic [bhwc_pkg::BAR_W-1:0]     out_bar,
  output logic                           zero_energy,
  output logic                           last_of_event
);
  import bhwc_pkg::*;

  localparam int PROD_W = COORD_BITS + ENERGY_BITS + 1;
  localparam int QW     = COORD_BITS + 1;
  localparam logic signed [ACC_EXT_W-1:0] AMAX =
    ACC_EXT_W'((64'd1 << (ACC_W - 1)) - 64'd1);
  localparam logic signed [ACC_EXT_W-1:0] AMIN = -AMAX - ACC_EXT_W'(1);
  localparam logic [QW-1:0] QLIM = QW'(1) << (COORD_BITS - 1);
  localparam logic [COORD_BITS-1:0] CMAX = COORD_BITS'(QLIM - QW'(1));

  // latched hit
  logic signed [COORD_BITS-1:0] x_r, y_r, z_r;
  logic [ENERGY_BITS-1:0]       e_r;
  logic [BAR_W-1:0]             bar_r;
  logic                         eoe_r;

  logic signed [PROD_W-1:0] px, py, pz;
  logic                     inside_r;

  // bar accumulators
  logic                    have_bar;
  logic [BAR_W-1:0]        cur_bar;
  logic [ESUM_W-1:0]       sum_e;
  logic signed [ACC_W-1:0] sum_wx, sum_wy, sum_wz;

  logic signed [COORD_BITS-1:0] res_x, res_y, res_z;

  logic signed [CMP_W-1:0] xw, ax;
  logic                    in_box;
  logic                    start_bar;
  logic [ESUM_W:0]         esum_ext;
  logic [ESUM_W-1:0]       esum_sat;
  logic signed [ACC_W-1:0] sw_num, sw_store;
  logic [ACC_W:0]          mag;
  logic [DIV_W-1:0]        num;
  logic                    div_busy, div_done;
  logic [QW-1:0]           quo;
  logic                    out_free;

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0]  a,
    input logic signed [PROD_W-1:0] p
  );
    logic signed [ACC_EXT_W-1:0] s;
    s = ACC_EXT_W'(a) + ACC_EXT_W'(p);
    if (s > AMAX) s = AMAX;
    if (s < AMIN) s = AMIN;
    return s[ACC_W-1:0];
  endfunction

  // clamp quotient magnitude, then apply sign within the coordinate range
  function automatic logic signed [COORD_BITS-1:0] to_cent(
    input logic [QW-1:0] q,
    input logic          neg
  );
    logic [QW-1:0] qc;
    qc = (q > QLIM) ? QLIM : q;
    if (neg) return COORD_BITS'(-qc);
    if (qc == QLIM) return CMAX;
    return qc[COORD_BITS-1:0];
  endfunction

  assign xw = CMP_W'(x_r);
  assign ax = (xw < 0) ? -xw : xw;
  assign in_box = !(ax > $signed(CMP_W'(cfg.x_limit)) ||
                    CMP_W'(y_r) < CMP_W'($signed(cfg.y_low)) ||
                    CMP_W'(y_r) > CMP_W'($signed(cfg.y_high)) ||
                    CMP_W'(z_r) < CMP_W'($signed(cfg.z_low)) ||
                    CMP_W'(z_r) > CMP_W'($signed(cfg.z_high)));

  assign start_bar = !have_bar || (bar_r != cur_bar);
  assign esum_ext  = (start_bar ? (ESUM_W + 1)'(0) : (ESUM_W + 1)'(sum_e))
                     + (ESUM_W + 1)'(e_r);
  assign esum_sat  = esum_ext[ESUM_W] ? '1 : esum_ext[ESUM_W-1:0];

  always_comb begin
    case (cmd.num_sel)
      SEL_X:   sw_num = sum_wx;
      SEL_Y:   sw_num = sum_wy;
      SEL_Z:   sw_num = sum_wz;
      default: sw_num = sum_wx;
    endcase
    case (cmd.store_sel)
      SEL_X:   sw_store = sum_wx;
      SEL_Y:   sw_store = sum_wy;
      SEL_Z:   sw_store = sum_wz;
      default: sw_store = sum_wx;
    endcase
  end

  assign mag = (sw_num < 0) ? -(ACC_W + 1)'(sw_num) : (ACC_W + 1)'(sw_num);
  assign num = DIV_W'(mag) + DIV_W'(sum_e >> 1);

  bhwc_div #(.QW(QW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num),
    .den   (sum_e),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (quo)
  );

  assign out_free = !out_valid || !out_stall;

  assign status.in_box   = inside_r;
  assign status.have_bar = have_bar;
  assign status.bar_ne   = (bar_r != cur_bar);
  assign status.eoe      = eoe_r;
  assign status.e_zero   = (sum_e == '0);
  assign status.div_done = div_done;
  assign status.out_free = out_free;

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      x_r   <= x_pos;
      y_r   <= y_pos;
      z_r   <= z_pos;
      e_r   <= energy;
      bar_r <= bar_id;
      eoe_r <= end_of_event;
    end
    if (cmd.calc) begin
      px       <= x_r * $signed({1'b0, e_r});
      py       <= y_r * $signed({1'b0, e_r});
      pz       <= z_r * $signed({1'b0, e_r});
      inside_r <= in_box;
    end
    if (cmd.store) begin
      case (cmd.store_sel)
        SEL_X:   res_x <= to_cent(quo, sw_store < 0);
        SEL_Y:   res_y <= to_cent(quo, sw_store < 0);
        SEL_Z:   res_z <= to_cent(quo, sw_store < 0);
        default: res_x <= to_cent(quo, sw_store < 0);
      endcase
    end
    if (cmd.out_load) begin
      cent_x        <= status.e_zero ? '0 : res_x;
      cent_y        <= status.e_zero ? '0 : res_y;
      cent_z        <= status.e_zero ? '0 : res_z;
      out_bar       <= cur_bar;
      zero_energy   <= status.e_zero;
      last_of_event <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_bar <= 1'b0;
      cur_bar  <= '0;
      sum_e    <= '0;
      sum_wx   <= '0;
      sum_wy   <= '0;
      sum_wz   <= '0;
    end else if (cmd.clear) begin
      have_bar <= 1'b0;
      cur_bar  <= '0;
      sum_e    <= '0;
      sum_wx   <= '0;
      sum_wy   <= '0;
      sum_wz   <= '0;
    end else if (cmd.accum && inside_r) begin
      have_bar <= 1'b1;
      cur_bar  <= bar_r;
      sum_e    <= esum_sat;
      sum_wx   <= sat_add(start_bar ? '0 : sum_wx, px);
      sum_wy   <= sat_add(start_bar ? '0 : sum_wy, py);
      sum_wz   <= sat_add(start_bar ? '0 : sum_wz, pz);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result loaded over a pending transaction");

  a_clean_idle: assert property (@(posedge clk) disable iff (rst)
    !have_bar |-> (sum_e == '0 && sum_wx == '0 && sum_wy == '0 && sum_wz == '0))
    else $error("accumulators not clear without a bar");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_zero_cent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_energy) |-> (cent_x == '0 && cent_y == '0 && cent_z == '0))
    else $error("zero-energy centroid not zero");
`endif

endmodule

/* rtl/bhwc_ctrl.sv */
module bhwc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bhwc_pkg::status_t   status,
  output bhwc_pkg::cmd_t      cmd
);
  import bhwc_pkg::*;

  state_t     state, state_next;
  logic       emit_last;
  coord_sel_t sel;
  coord_sel_t sel_inc;

  always_comb begin
    case (sel)
      SEL_X:   sel_inc = SEL_Y;
      SEL_Y:   sel_inc = SEL_Z;
      default: sel_inc = SEL_X;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_PROD;
      S_PROD:   state_next = S_DECIDE;
      S_DECIDE: state_next = (status.in_box && status.have_bar && status.bar_ne) ?
                             S_EMIT : S_ACCUM;
      S_EMIT:   state_next = status.e_zero ? S_OUT : S_DIV;
      S_DIV:    if (status.div_done && sel == SEL_Z) state_next = S_OUT;
      S_OUT:    if (status.out_free) state_next = emit_last ? S_IDLE : S_ACCUM;
      S_ACCUM:  state_next = S_EOE;
      S_EOE:    state_next = (status.eoe && status.have_bar) ? S_EMIT : S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.num_sel   = SEL_X;
    cmd.store_sel = sel;
    in_stall      = (state != S_IDLE);
    case (state)
      S_IDLE:  cmd.take_in = in_valid;
      S_PROD:  cmd.calc = 1'b1;
      S_EMIT:  cmd.div_start = !status.e_zero;
      S_DIV: begin
        cmd.store     = status.div_done;
        cmd.div_start = status.div_done && sel != SEL_Z;
        cmd.num_sel   = sel_inc;
      end
      S_OUT: begin
        cmd.out_load = status.out_free;
        cmd.out_last = emit_last;
        cmd.clear    = status.out_free && emit_last;
      end
      S_ACCUM: cmd.accum = 1'b1;
      default: cmd.take_in = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      emit_last <= 1'b0;
      sel       <= SEL_X;
    end else begin
      state <= state_next;
      if (state == S_DECIDE) emit_last <= 1'b0;
      if (state == S_EOE)    emit_last <= 1'b1;
      if (state == S_EMIT)   sel <= SEL_X;
      if (state == S_DIV && status.div_done) sel <= sel_inc;
    end
  end

endmodule

/* rtl/bar_hit_weighted_centroid.sv */
// energy-weighted centroid per detector bar
// input channel: one hit per transaction (position, energy, bar id, end_of_event),
//   taken when in_valid is high and in_stall is low
// hits outside the configured box are dropped; runs of hits on the same bar are
//   summed with saturating accumulators
// output channel: one centroid per finished bar, held in an output register until
//   out_valid is high and out_stall is low; a bar change and an end of event on
//   the same hit give two transactions, finished bar first
// sequence: a hit that finishes no bar passes the product, decide, accumulate and
//   end-of-event states; a centroid of a bar with nonzero energy also runs the
//   shared iterative divider, one quotient bit per cycle, over x, y then z
// one hit is in work at a time; in_stall is high from acceptance until done
// a stalled receiver holds the result in the output register and the block
//   waits only when a further centroid is ready to be loaded
// reset (synchronous, rst high) clears the bar state, drops any pending result
//   and restores the box limits to their defaults
// box limits must be written over the apb port only while idle; not enforced
module bar_hit_weighted_centroid #(
  parameter int COORD_BITS  = bhwc_pkg::DEF_COORD_BITS,
  parameter int ENERGY_BITS = bhwc_pkg::DEF_ENERGY_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  // apb configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bhwc_pkg::ADDR_W-1:0]      paddr,
  input  logic [bhwc_pkg::DATA_W-1:0]      pwdata,
  output logic [bhwc_pkg::DATA_W-1:0]      prdata,
  output logic                             pready,
  // hit channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [COORD_BITS-1:0]     x_pos,
  input  logic signed [COORD_BITS-1:0]     y_pos,
  input  logic signed [COORD_BITS-1:0]     z_pos,
  input  logic [ENERGY_BITS-1:0]           energy,
  input  logic [bhwc_pkg::BAR_W-1:0]       bar_id,
  input  logic                             end_of_event,
  // centroid channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [COORD_BITS-1:0]     cent_x,
  output logic signed [COORD_BITS-1:0]     cent_y,
  output logic signed [COORD_BITS-1:0]     cent_z,
  output logic [bhwc_pkg::BAR_W-1:0]       out_bar,
  output logic                             zero_energy,
  output logic                             last_of_event
);
  import bhwc_pkg::*;

  cfg_t     cfg;
  cmd_t     cmd;
  status_t  status;
  reg_idx_t reg_idx;
  logic     wr_en;

  // registers sit at word addresses, index from paddr bits above the byte lane
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_limit <= X_LIMIT_RST;
      cfg.y_low   <= Y_LOW_RST;
      cfg.y_high  <= Y_HIGH_RST;
      cfg.z_low   <= Z_LOW_RST;
      cfg.z_high  <= Z_HIGH_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_X_LIMIT: cfg.x_limit <= pwdata[XLIM_W-1:0];
        REG_Y_LOW:   cfg.y_low   <= pwdata[BOUND_W-1:0];
        REG_Y_HIGH:  cfg.y_high  <= pwdata[BOUND_W-1:0];
        REG_Z_LOW:   cfg.z_low   <= pwdata[BOUND_W-1:0];
        REG_Z_HIGH:  cfg.z_high  <= pwdata[BOUND_W-1:0];
        default:     cfg.x_limit <= cfg.x_limit;
      endcase
    end
  end

  // read back raw register bits, zero-extended
  always_comb begin
    case (reg_idx)
      REG_X_LIMIT: prdata = DATA_W'(cfg.x_limit);
      REG_Y_LOW:   prdata = DATA_W'(cfg.y_low);
      REG_Y_HIGH:  prdata = DATA_W'(cfg.y_high);
      REG_Z_LOW:   prdata = DATA_W'(cfg.z_low);
      REG_Z_HIGH:  prdata = DATA_W'(cfg.z_high);
      default:     prdata = '0;
    endcase
  end

  // sequencer: steps each hit through box check, bar change, division and flush
  bhwc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: products, saturating sums, divider and output register
  bhwc_dp #(
    .COORD_BITS  (COORD_BITS),
    .ENERGY_BITS (ENERGY_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .status        (status),
    .x_pos         (x_pos),
    .y_pos         (y_pos),
    .z_pos         (z_pos),
    .energy        (energy),
    .bar_id        (bar_id),
    .end_of_event  (end_of_event),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cent_x        (cent_x),
    .cent_y        (cent_y),
    .cent_z        (cent_z),
    .out_bar       (out_bar),
    .zero_energy   (zero_energy),
    .last_of_event (last_of_event)
  );

endmodule

/* sim/tb_bar_hit_weighted_centroid.sv */
`timescale 1ns / 100ps

module tb_bar_hit_weighted_centroid;
  import bhwc_pkg::*;

  localparam int CB = DEF_COORD_BITS;
  localparam int EB = DEF_ENERGY_BITS;
  localparam longint ACC_HI = 64'sh7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint C_HI = (64'sd1 <<< (CB - 1)) - 1;
  localparam longint C_LO = -C_HI - 1;
  // watchdog bound, several times the slowest legal run
  localparam int CYCLE_LIMIT = 3000000;
  // one hit plus two centroids through the shared divider, with margin
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
    logic [EB-1:0]        e;
    logic [BAR_W-1:0]     bar;
    logic                 eoe;
  } hit_t;

  typedef struct packed {
    logic signed [CB-1:0] cx;
    logic signed [CB-1:0] cy;
    logic signed [CB-1:0] cz;
    logic [BAR_W-1:0]     bar;
    logic                 zero;
    logic                 last;
  } cent_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CB-1:0] x_pos = '0, y_pos = '0, z_pos = '0;
  logic [EB-1:0] energy = '0;
  logic [BAR_W-1:0] bar_id = '0;
  logic end_of_event = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [CB-1:0] cent_x, cent_y, cent_z;
  logic [BAR_W-1:0] out_bar;
  logic zero_energy, last_of_event;

  bar_hit_weighted_centroid u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .x_pos(x_pos), .y_pos(y_pos), .z_pos(z_pos), .energy(energy),
    .bar_id(bar_id), .end_of_event(end_of_event),
    .out_valid(out_valid), .out_stall(out_stall),
    .cent_x(cent_x), .cent_y(cent_y), .cent_z(cent_z), .out_bar(out_bar),
    .zero_energy(zero_energy), .last_of_event(last_of_event)
  );

  // stimulus and expectations
  hit_t  hit_queue[$];
  cent_t cent_expected[$];
  int    send_idle_pct = 0;
  int    stall_pct = 0;
  int    mismatches = 0;
  int    cycles = 0;

  // predictor copy of the box limits
  logic [XLIM_W-1:0]         box_xlim = X_LIMIT_RST;
  logic signed [BOUND_W-1:0] box_ylo = Y_LOW_RST;
  logic signed [BOUND_W-1:0] box_yhi = Y_HIGH_RST;
  logic signed [BOUND_W-1:0] box_zlo = Z_LOW_RST;
  logic signed [BOUND_W-1:0] box_zhi = Z_HIGH_RST;

  // predictor copy of the bar accumulators
  logic              bar_open = 1'b0;
  logic [BAR_W-1:0]  open_bar = '0;
  longint unsigned   esum = 0;
  longint            wx = 0, wy = 0, wz = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // append a hit to the pending stimulus
  function automatic void queue_hit(hit_t h);
    hit_queue.insert(hit_queue.size(), h);
  endfunction

  // append a centroid to the expected results
  function automatic void expect_cent(cent_t c);
    cent_expected.insert(cent_expected.size(), c);
  endfunction

  // rounded mean, ties away from zero, clamped to the coordinate range
  function automatic logic signed [CB-1:0] round_mean(longint sw, longint unsigned e);
    longint unsigned mag;
    longint unsigned q;
    longint r;
    mag = (sw < 0) ? longint'(-sw) : longint'(sw);
    q = (mag + e / 2) / e;
    if (q > longint'(C_HI) + 1) q = longint'(C_HI) + 1;
    r = (sw < 0) ? -longint'(q) : longint'(q);
    if (r > C_HI) r = C_HI;
    if (r < C_LO) r = C_LO;
    return r[CB-1:0];
  endfunction

  function automatic longint sat_add(longint acc, longint add);
    longint s;
    s = acc + add;
    if (s > ACC_HI) return ACC_HI;
    if (s < ACC_LO) return ACC_LO;
    return s;
  endfunction

  function automatic void close_bar(logic last);
    cent_t c;
    if (esum == 0) begin
      c.cx = '0; c.cy = '0; c.cz = '0; c.zero = 1'b1;
    end else begin
      c.cx = round_mean(wx, esum);
      c.cy = round_mean(wy, esum);
      c.cz = round_mean(wz, esum);
      c.zero = 1'b0;
    end
    c.bar = open_bar;
    c.last = last;
    expect_cent(c);
  endfunction

  function automatic void clear_bar(logic [BAR_W-1:0] b);
    open_bar = b;
    esum = 0; wx = 0; wy = 0; wz = 0;
  endfunction

  // accumulate one accepted hit, queueing the centroids it finishes
  function automatic void accumulate_hit(hit_t h);
    longint x, y, z, ax, e;
    logic in_box;
    x = h.x; y = h.y; z = h.z; e = h.e;
    ax = (x < 0) ? -x : x;
    in_box = !(ax > longint'(box_xlim) || y < box_ylo || y > box_yhi ||
               z < box_zlo || z > box_zhi);
    if (in_box) begin
      if (bar_open && h.bar != open_bar) begin
        close_bar(1'b0);
        clear_bar(h.bar);
      end else if (!bar_open) begin
        clear_bar(h.bar);
      end
      bar_open = 1'b1;
      esum = esum + longint'(e);
      if (esum > 64'hFFFF_FFFF) esum = 64'hFFFF_FFFF;
      wx = sat_add(wx, x * e);
      wy = sat_add(wy, y * e);
      wz = sat_add(wz, z * e);
    end
    // end of event flushes the pending bar even when this hit was dropped
    if (h.eoe && bar_open) begin
      close_bar(1'b1);
      bar_open = 1'b0;
      clear_bar('0);
    end
  endfunction

  // driver: hits from the queue, with random gaps
  always @(posedge clk) begin
    hit_t h;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        accumulate_hit({x_pos, y_pos, z_pos, energy, bar_id, end_of_event});
      end
      if (!in_valid || !in_stall) begin
        if (hit_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          h = hit_queue.pop_front();
          in_valid <= 1'b1;
          x_pos <= h.x; y_pos <= h.y; z_pos <= h.z;
          energy <= h.e; bar_id <= h.bar; end_of_event <= h.eoe;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, each centroid checked against the oldest expectation
  always @(posedge clk) begin
    cent_t want, got;
    if (!rst) begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (out_valid && !out_stall) begin
        got = {cent_x, cent_y, cent_z, out_bar, zero_energy, last_of_event};
        if (cent_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected centroid: bar %h x %0d y %0d z %0d zero %b last %b",
                     got.bar, got.cx, got.cy, got.cz, got.zero, got.last);
        end else begin
          want = cent_expected.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("centroid mismatch: exp bar %h x %0d y %0d z %0d zero %b last %b",
                       want.bar, want.cx, want.cy, want.cz, want.zero, want.last);
              $display("                   got bar %h x %0d y %0d z %0d zero %b last %b",
                       got.bar, got.cx, got.cy, got.cz, got.zero, got.last);
            end
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[bar_hit_weighted_centroid] ERROR");
      $finish;
    end
  end

  task automatic apb_write(reg_idx_t idx, logic [DATA_W-1:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * int'(idx)); pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // writes all five limits and mirrors them in the predictor
  task automatic set_box(int xl, int ylo, int yhi, int zlo, int zhi);
    apb_write(REG_X_LIMIT, DATA_W'(xl));
    apb_write(REG_Y_LOW, DATA_W'(ylo));
    apb_write(REG_Y_HIGH, DATA_W'(yhi));
    apb_write(REG_Z_LOW, DATA_W'(zlo));
    apb_write(REG_Z_HIGH, DATA_W'(zhi));
    box_xlim = xl[XLIM_W-1:0];
    box_ylo = ylo[BOUND_W-1:0]; box_yhi = yhi[BOUND_W-1:0];
    box_zlo = zlo[BOUND_W-1:0]; box_zhi = zhi[BOUND_W-1:0];
  endtask

  // sender holds off until every centroid is out and the block has settled
  task automatic drain;
    while (hit_queue.size() > 0 || in_valid || cent_expected.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic hit_t mk_hit(int x, int y, int z, int e, logic [31:0] b, logic eoe);
    hit_t h;
    h.x = x[CB-1:0]; h.y = y[CB-1:0]; h.z = z[CB-1:0];
    h.e = e[EB-1:0]; h.bar = b; h.eoe = eoe;
    return h;
  endfunction

  // mostly inside the current box, sometimes anywhere
  function automatic int coord_in(int lo, int hi);
    if (lo <= hi && $urandom_range(9) < 8)
      return lo + int'($urandom_range(hi - lo));
    return int'($urandom_range(262143)) - 131072;
  endfunction

  function automatic hit_t rand_hit(logic [31:0] b, logic eoe);
    int x, e;
    if ($urandom_range(9) < 8) begin
      x = int'($urandom_range(int'(box_xlim)));
      if ($urandom_range(1)) x = -x;
    end else begin
      x = int'($urandom_range(262143)) - 131072;
    end
    case ($urandom_range(9))
      0: e = 0;
      1: e = 65535;
      default: e = int'($urandom_range(65535));
    endcase
    return mk_hit(x, coord_in(box_ylo, box_yhi), coord_in(box_zlo, box_zhi), e, b, eoe);
  endfunction

  // events built from runs of hits on one bar, with some noise mixed in
  task automatic queue_events(int n);
    int cnt, nbars, nhits;
    logic [31:0] b;
    hit_t h;
    cnt = 0;
    while (cnt < n) begin
      nbars = $urandom_range(1, 4);
      for (int i = 0; i < nbars; i++) begin
        b = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(7));
        nhits = $urandom_range(1, 5);
        for (int j = 0; j < nhits; j++) begin
          if ($urandom_range(9) == 0)
            h = mk_hit(int'($urandom()), int'($urandom()), int'($urandom()),
                       int'($urandom()), $urandom(), $urandom_range(1));
          else
            h = rand_hit(b, (i == nbars - 1 && j == nhits - 1) ||
                            ($urandom_range(19) == 0));
          queue_hit(h);
          cnt++;
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // phase 0: box wide open, directed corners then random, no idling
    set_box(131071, -131072, 131071, -131072, 131071);
    // extreme positions and full energy on one bar
    queue_hit(mk_hit(131071, 131071, 131071, 65535, 32'h0, 1'b0));
    queue_hit(mk_hit(-131071, -131072, -131072, 65535, 32'h0, 1'b0));
    // most negative x is never inside the box
    queue_hit(mk_hit(-131072, 0, 0, 100, 32'h0, 1'b0));
    // bar change then end of event on a dropped hit
    queue_hit(mk_hit(5, -7, 3, 3, 32'hFFFF_FFFF, 1'b0));
    queue_hit(mk_hit(-131072, 1, 1, 1, 32'h1234, 1'b1));
    // end of event with nothing pending, then a lone zero-energy hit ending its event
    queue_hit(mk_hit(-131072, 0, 0, 0, 32'h1, 1'b1));
    queue_hit(mk_hit(10, 10, 10, 0, 32'h2, 1'b1));
    // zero energy bar
    queue_hit(mk_hit(100, 200, 300, 0, 32'h5, 1'b0));
    queue_hit(mk_hit(-100, 200, 300, 0, 32'h5, 1'b0));
    // bar change and end of event on the same hit
    queue_hit(mk_hit(1, 2, 3, 2, 32'h6, 1'b0));
    queue_hit(mk_hit(-1, -2, -3, 2, 32'h7, 1'b1));
    // rounding ties: mean of 1 and 2, and of -1 and -2
    queue_hit(mk_hit(1, -1, 0, 1, 32'h8, 1'b0));
    queue_hit(mk_hit(2, -2, 0, 1, 32'h8, 1'b1));
    queue_hit(mk_hit(0, 0, 0, 1, 32'hAAAA_5555, 1'b0));
    queue_hit(mk_hit(-1, 131071, -131072, 65535, 32'h5555_AAAA, 1'b1));
    queue_events(400);
    drain();

    // phase 1: reset box, sender mostly idle
    set_box(16000, -15695, 16305, 13440, 88704);
    send_idle_pct = 84; stall_pct = 0;
    queue_events(400);
    drain();

    // phase 2: random box, receiver mostly stalling
    begin
      int a, b2, c, d;
      a = int'($urandom_range(262143)) - 131072;
      b2 = int'($urandom_range(262143)) - 131072;
      c = int'($urandom_range(262143)) - 131072;
      d = int'($urandom_range(262143)) - 131072;
      set_box(int'($urandom_range(131071)), (a < b2) ? a : b2, (a < b2) ? b2 : a,
              (c < d) ? c : d, (c < d) ? d : c);
    end
    send_idle_pct = 0; stall_pct = 84;
    queue_events(400);
    drain();

    // phase 3: zero x limit, some idling on both sides
    set_box(0, -131072, 131071, -131072, 131071);
    send_idle_pct = 14; stall_pct = 14;
    queue_events(450);
    drain();

    if (mismatches == 0) begin
      $display("[bar_hit_weighted_centroid] OK");
    end else begin
      $display("[bar_hit_weighted_centroid] ERROR");
    end
    $finish;
  end

endmodule
